FILE: src/plwv_pkg.sv
// Shared types and constants for the presence line window vote filter.
// No dependencies; imported by every module of the block.
package plwv_pkg;

  // Window length in samples and derived widths
  localparam int WINDOW  = 16;
  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int THR_W   = 5;
  localparam int VCNT_W  = 5;
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int BYTE_W  = 8;

  // Front-to-back sample queue
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Threshold after reset
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  // What the current line holds so far
  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_OTHER = 2'd3
  } line_kind_t;

  // Presence change reported with each sample
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ARRIVE = 2'd1,
    EV_LEAVE  = 2'd2
  } event_t;

  // One classified sample moving from the front to the queue
  typedef struct packed {
    logic valid;
    logic one;
  } smp_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic valid;
    logic one;
  } qhead_t;

endpackage

FILE: src/plwv_front.sv
// Line parser: splits bytes into CR LF terminated lines and classifies them.
// Depends on plwv_pkg; feeds presence samples to plwv_queue.
module plwv_front
  import plwv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output smp_t              smp
);

  logic       cr_seen_r, cr_seen_nxt;
  line_kind_t kind_r, kind_nxt;

  // Advance the line state on each accepted beat
  always_comb begin
    cr_seen_nxt = cr_seen_r;
    kind_nxt    = kind_r;
    smp.valid   = 1'b0;
    smp.one     = 1'b0;
    if (accept) begin
      if (cr_seen_r) begin
        cr_seen_nxt = 1'b0;
        if (rx_byte == CH_LF) begin
          kind_nxt  = KIND_EMPTY;
          smp.valid = (kind_r == KIND_ONE) || (kind_r == KIND_ZERO);
          smp.one   = (kind_r == KIND_ONE);
        end
      end else if (rx_byte == CH_CR) begin
        cr_seen_nxt = 1'b1;
      end else if (kind_r == KIND_EMPTY && rx_byte == CH_ONE) begin
        kind_nxt = KIND_ONE;
      end else if (kind_r == KIND_EMPTY && rx_byte == CH_ZERO) begin
        kind_nxt = KIND_ZERO;
      end else begin
        kind_nxt = KIND_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_seen_r <= 1'b0;
      kind_r    <= KIND_EMPTY;
    end else begin
      cr_seen_r <= cr_seen_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule

FILE: src/plwv_queue.sv
// Short sample queue between the line parser and the window vote.
// Depends on plwv_pkg; written by plwv_front, drained by plwv_back.
module plwv_queue
  import plwv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  smp_t   smp,
  input  logic   deq,
  output qhead_t head,
  output logic   full
);

  logic [QDEPTH-1:0] data_r;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.one   = data_r[rd_ptr_r];
  assign do_push    = smp.valid;
  assign do_pop     = deq && head.valid;

  // Step pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store the pushed sample
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= smp.one;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

FILE: src/plwv_back.sv
// Window vote: ring of samples, running ones count, threshold and result register.
// Depends on plwv_pkg; drains plwv_queue and drives the result ports.
module plwv_back
  import plwv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_wdata,
  input  qhead_t            head,
  output logic              deq,
  output logic              out_valid,
  input  logic              out_take,
  output logic              present,
  output logic [1:0]        event_res,
  output logic [VCNT_W-1:0] vote_count
);

  logic [WINDOW-1:0] ring_r, ring_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cnt_upd;
  logic [THR_W-1:0]  thr_r;
  logic              last_r, last_nxt;
  logic              valid_r, valid_nxt;
  logic              pres_r, pres_nxt;
  event_t            ev_r, ev_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [CMP_W-1:0]  cnt_ext, thr_ext;
  logic              now;

  // Take a sample when the result register is free or being drained
  assign deq     = head.valid && (!valid_r || out_take);
  assign cnt_upd = cnt_r - CNT_W'(ring_r[idx_r]) + CNT_W'(head.one);
  assign cnt_ext = CMP_W'(cnt_upd);
  assign thr_ext = CMP_W'(thr_r);
  assign now     = (cnt_ext >= thr_ext);

  // Replace the oldest bit, update the count and vote
  always_comb begin
    ring_nxt  = ring_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !out_take;
    pres_nxt  = pres_r;
    ev_nxt    = ev_r;
    vcnt_nxt  = vcnt_r;
    if (deq) begin
      ring_nxt[idx_r] = head.one;
      idx_nxt   = (idx_r == IDX_W'(WINDOW - 1)) ? '0 : idx_r + 1'b1;
      cnt_nxt   = cnt_upd;
      last_nxt  = now;
      valid_nxt = 1'b1;
      pres_nxt  = now;
      vcnt_nxt  = cnt_ext[VCNT_W-1:0];
      if (!last_r && now) begin
        ev_nxt = EV_ARRIVE;
      end else if (last_r && !now) begin
        ev_nxt = EV_LEAVE;
      end else begin
        ev_nxt = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r  <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      valid_r <= 1'b0;
      thr_r   <= THR_RESET;
    end else begin
      ring_r  <= ring_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
    ev_r   <= ev_nxt;
    vcnt_r <= vcnt_nxt;
  end

  assign out_valid  = valid_r;
  assign present    = pres_r;
  assign event_res  = ev_r;
  assign vote_count = vcnt_r;

  a_count_matches_ring: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ring_r) == int'(cnt_r))
    else $error("ones count out of step with ring");

  a_arrive_present: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_ARRIVE) |-> pres_r)
    else $error("arrive event without presence");

  a_leave_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_LEAVE) |-> !pres_r)
    else $error("leave event with presence");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    deq |=> (pres_r == last_r))
    else $error("result level differs from held presence");

endmodule

FILE: src/presence_line_window_vote.sv
// Empty falls once the sample from a line-ending LF beat has passed the queue and is registered as a result.
// Throughput: one byte per cycle while full is low; one result per cycle when pop keeps up.
// The ring update, count step and threshold compare are combinational in the back part and registered together.
// Reset (rst_n low, synchronous) empties the queue, clears the ring and count,
// clears the held presence behind the arrive/leave events, and sets the threshold to 8.
module presence_line_window_vote
  import plwv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              empty,
  input  logic              pop,
  output logic              out_present,
  output logic [1:0]        out_event_res,
  output logic [VCNT_W-1:0] out_vote_count
);

  smp_t   smp;
  qhead_t head;
  logic   q_full;
  logic   deq;
  logic   out_valid;
  logic   in_acc;

  // Accept a byte beat whenever the sample queue has room
  assign full   = q_full;
  assign in_acc = push && !q_full;
  assign empty  = !out_valid;

  plwv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .rx_byte (in_rx_byte),
    .smp     (smp)
  );

  plwv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .smp   (smp),
    .deq   (deq),
    .head  (head),
    .full  (q_full)
  );

  plwv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .deq        (deq),
    .out_valid  (out_valid),
    .out_take   (pop),
    .present    (out_present),
    .event_res  (out_event_res),
    .vote_count (out_vote_count)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for presence_line_window_vote: serial lines in, vote results out.
// Depends on plwv_pkg and the presence_line_window_vote RTL; reads no files.
module tb;
  import plwv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BYTE_W-1:0] byte_seq_t[$];

  typedef struct {
    logic              present;
    event_t            ev;
    logic [VCNT_W-1:0] count;
  } vote_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [THR_W-1:0]  cfg_wdata  = '0;
  logic              push       = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              empty;
  logic              pop        = 1'b0;
  logic              out_present;
  logic [1:0]        out_event_res;
  logic [VCNT_W-1:0] out_vote_count;

  // Idling switches for the sending and receiving sides
  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;
  int errors   = 0;

  // Mirror of the filter state
  bit [WINDOW-1:0]  vote_ring   = '0;
  int               ring_pos    = 0;
  int               ones_held   = 0;
  bit               was_present = 1'b0;
  bit               cr_pending  = 1'b0;
  line_kind_t       cur_kind    = KIND_EMPTY;
  logic [THR_W-1:0] thr_model   = THR_RESET;

  vote_result_t expected_votes[$];

  presence_line_window_vote u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .in_rx_byte    (in_rx_byte),
    .empty         (empty),
    .pop           (pop),
    .out_present   (out_present),
    .out_event_res (out_event_res),
    .out_vote_count(out_vote_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Push one sample into the window and queue the vote it yields
  function automatic void take_vote(bit one);
    vote_result_t r;
    bit           now_present;
    if (vote_ring[ring_pos] && ones_held > 0) ones_held--;
    vote_ring[ring_pos] = one;
    if (one) ones_held++;
    ring_pos = (ring_pos + 1) % WINDOW;
    now_present = (ones_held >= int'(thr_model));
    r.ev = EV_NONE;
    if (!was_present && now_present) r.ev = EV_ARRIVE;
    else if (was_present && !now_present) r.ev = EV_LEAVE;
    was_present = now_present;
    r.present = now_present;
    r.count   = VCNT_W'(ones_held);
    expected_votes.push_back(r);
  endfunction

  // Advance line framing by one accepted byte
  function automatic void track_byte(logic [BYTE_W-1:0] ch);
    line_kind_t done_kind;
    if (cr_pending) begin
      // only LF closes the line; anything else after CR is dropped
      cr_pending = 1'b0;
      if (ch == CH_LF) begin
        done_kind = cur_kind;
        cur_kind  = KIND_EMPTY;
        if (done_kind == KIND_ONE) take_vote(1'b1);
        else if (done_kind == KIND_ZERO) take_vote(1'b0);
      end
    end else if (ch == CH_CR) begin
      cr_pending = 1'b1;
    end else if (cur_kind == KIND_EMPTY && ch == CH_ONE) begin
      cur_kind = KIND_ONE;
    end else if (cur_kind == KIND_EMPTY && ch == CH_ZERO) begin
      cur_kind = KIND_ZERO;
    end else begin
      cur_kind = KIND_OTHER;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Send one byte; returns right after the edge that accepts it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full !== 1'b0);
    track_byte(b);
  endtask

  task automatic send_seq(input byte_seq_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Hold off until every expected vote is out and the pipeline has settled
  task automatic wait_quiet();
    push <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model = v;
    @(posedge clk);
  endtask

  // Build one random line: mostly samples, the rest noise and broken framing
  function automatic byte_seq_t make_line(int one_pct);
    byte_seq_t q;
    int        pick;
    int        n;
    logic [BYTE_W-1:0] s;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 99) < one_pct) ? CH_ONE : CH_ZERO;
    if (pick < 58) begin
      q = '{s, CH_CR, CH_LF};
    end else if (pick < 66) begin
      // stray byte after CR gets dropped, line goes on, unless the stray byte is LF
      q = '{s, CH_CR, 8'($urandom_range(0, 255)), CH_CR, CH_LF};
    end else if (pick < 74) begin
      q = '{CH_CR, CH_LF};
    end else if (pick < 82) begin
      q = '{s, 8'($urandom_range(0, 255)), CH_CR, CH_LF};
    end else if (pick < 90) begin
      n = $urandom_range(1, 4);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      q.push_back(CH_CR);
      q.push_back(CH_LF);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // Line framing: samples, empty and long lines, byte extremes, CR oddities
  task automatic test_line_framing();
    send_seq('{CH_ZERO, CH_CR, CH_LF});
    send_seq('{CH_ONE, CH_CR, CH_LF});
    send_seq('{8'h00, 8'hFF, CH_CR, CH_LF});
    send_seq('{CH_CR, CH_LF});
    send_seq('{CH_ONE, CH_CR, 8'hFF, CH_CR, CH_LF});
    send_seq('{CH_CR, CH_CR, CH_LF});
    send_seq('{CH_ONE, CH_ZERO, CH_CR, CH_LF});
  endtask

  // Threshold zero always votes present; threshold above the window never does
  task automatic test_threshold_extremes();
    wait_quiet();
    write_threshold(THR_W'(0));
    send_seq('{CH_ZERO, CH_CR, CH_LF});
    wait_quiet();
    write_threshold(THR_W'(31));
    send_seq('{CH_ONE, CH_CR, CH_LF});
  endtask

  // Random lines in phases, each with its own threshold and idling, and a bias that swings within the phase
  task automatic test_random_traffic();
    logic [THR_W-1:0] thr_list[5] = '{THR_W'(16), THR_W'(0), THR_W'(31), THR_W'(1),
                                      THR_W'(17)};
    logic [THR_W-1:0] thr;
    byte_seq_t        line;
    int               sent;
    int               phase;
    int               one_pct;
    sent  = 0;
    phase = 0;
    while (sent < 700) begin
      wait_quiet();
      if (phase < 5) thr = thr_list[phase];
      else if ($urandom_range(0, 7) == 0) thr = THR_W'($urandom_range(17, 31));
      else thr = THR_W'($urandom_range(0, 16));
      write_threshold(thr);
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 32 && sent < 700; k++) begin
        // swing the bias so the count sweeps across the threshold
        if (k % 8 == 0) one_pct = $urandom_range(0, 100);
        line = make_line(one_pct);
        send_seq(line);
        sent += line.size();
      end
      phase++;
    end
  endtask

  // Accept results with random pop gaps and compare against the oldest vote
  initial begin
    vote_result_t r;
    int           gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = out_idle ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        pop <= 1'b0;
        @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (expected_votes.size() == 0) begin
        flag_mismatch("unexpected beat", {out_present, out_event_res, out_vote_count},
                      8'h00);
      end else begin
        r = expected_votes.pop_front();
        if (out_present !== r.present) flag_mismatch("present", out_present, r.present);
        if (out_event_res !== r.ev) flag_mismatch("event_res", out_event_res, r.ev);
        if (out_vote_count !== r.count) flag_mismatch("vote_count", out_vote_count, r.count);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_line_framing();
    test_threshold_extremes();
    test_random_traffic();
    wait_quiet();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
src/plwv_pkg.sv
src/plwv_front.sv
src/plwv_queue.sv
src/plwv_back.sv
src/presence_line_window_vote.sv
sim/tb.sv
